// File: src/double_ended_priority_queue_unit_defines.svh
// Assertion macros used by the queue RTL.
// Both expect clk in scope; DEPQ_ASSERT also expects arst_n.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Checked outside reset only
`define DEPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define DEPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/depq_pkg.sv
package depq_pkg;

	// Default sizing
	localparam int DEF_CAPACITY      = 64;
	localparam int DEF_PRIORITY_BITS = 24;
	localparam int DEF_ID_BITS       = 20;

	// Repeat counter per entry
	localparam int                     REPEAT_BITS = 7;
	localparam logic [REPEAT_BITS-1:0] REPEAT_MAX  = 7'd127;
	localparam logic [REPEAT_BITS-1:0] REPEAT_ONE  = 7'd1;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP_HI = 2'd1,
		CMD_POP_LO = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic apply;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic res_needed;
		logic out_free;
	} sts_t;

endpackage

// File: src/depq_ctrl.sv
module depq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  depq_pkg::sts_t sts,
	output depq_pkg::ctl_t ctl
);
	import depq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state: capture, compare, update
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				state_nxt = S_APPLY;
			end
			S_APPLY: begin
				// hold while a result has nowhere to go
				if (!sts.res_needed || sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ctl           = '0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				ctl.load      = s_axis_tvalid;
			end
			S_CMP: begin
				ctl.compare = 1'b1;
			end
			S_APPLY: begin
				ctl.apply = !sts.res_needed || sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

// File: src/depq_store.sv
`include "double_ended_priority_queue_unit_defines.svh"

module depq_store #(
	parameter int CAPACITY      = depq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = depq_pkg::DEF_PRIORITY_BITS,
	parameter int ID_BITS       = depq_pkg::DEF_ID_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  depq_pkg::ctl_t           ctl,
	output depq_pkg::sts_t           sts,
	input  logic [1:0]               in_cmd,
	input  logic [ID_BITS-1:0]       in_id,
	input  logic [PRIORITY_BITS-1:0] in_prio,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ID_BITS-1:0]       out_id,
	output logic [1:0]               out_status
);
	import depq_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

	// Captured item
	cmd_t                     cmd_q;
	logic [ID_BITS-1:0]       id_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// Sorted entry cells, ascending from cell 0
	logic [PRIORITY_BITS-1:0] pri_q [CAPACITY];
	logic [ID_BITS-1:0]       own_q [CAPACITY];
	logic [REPEAT_BITS-1:0]   rep_q [CAPACITY];
	logic [OCC_W-1:0]         occ_q;

	// Per-cell compare flags
	logic [CAPACITY-1:0] lt_q;
	logic [CAPACITY-1:0] eq_q;
	logic [CAPACITY-1:0] sat_q;
	logic [CAPACITY-1:0] last_q;
	logic [CAPACITY-1:0] multi_q;

	// Output register
	logic               out_valid_q;
	logic [ID_BITS-1:0] out_id_q;
	status_t            out_status_q;

	logic               dup;
	logic               drop;
	logic               is_pop;
	logic               empty;
	logic               hi_remove;
	logic               res_needed;
	logic [ID_BITS-1:0] hi_id;

	// Input capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_t'(in_cmd);
			id_q   <= in_id;
			prio_q <= in_prio;
		end
	end

	// Decisions from the registered flags
	assign dup       = |eq_q;
	assign drop      = dup ? (|sat_q) : (occ_q == OCC_FULL);
	assign is_pop    = (cmd_q == CMD_POP_HI) || (cmd_q == CMD_POP_LO);
	assign empty     = (occ_q == '0);
	assign hi_remove = |(last_q & ~multi_q);

	always_comb begin
		unique case (cmd_q)
			CMD_INSERT: res_needed = drop;
			CMD_POP_HI: res_needed = 1'b1;
			CMD_POP_LO: res_needed = 1'b1;
			default:    res_needed = 1'b0;
		endcase
	end

	// One-hot pick of the top entry's owner
	always_comb begin
		hi_id = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hi_id = hi_id | (own_q[i] & {ID_BITS{last_q[i]}});
		end
	end

	assign sts.res_needed = res_needed;
	assign sts.out_free   = !out_valid_q || out_ready;

	// Cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     valid;
		logic                     valid_next;
		logic                     lt_prev;
		logic                     take_new;
		logic                     take_up;
		logic [PRIORITY_BITS-1:0] up_pri;
		logic [ID_BITS-1:0]       up_own;
		logic [REPEAT_BITS-1:0]   up_rep;
		logic [PRIORITY_BITS-1:0] dn_pri;
		logic [ID_BITS-1:0]       dn_own;
		logic [REPEAT_BITS-1:0]   dn_rep;
		logic                     has_dn;

		assign valid      = OCC_W'(i) < occ_q;
		assign valid_next = OCC_W'(i + 1) < occ_q;

		// neighbour below (lower index) feeds an insert shift
		if (i == 0) begin : g_first
			assign lt_prev = 1'b1;
			assign up_pri  = '0;
			assign up_own  = '0;
			assign up_rep  = '0;
		end else begin : g_rest
			assign lt_prev = lt_q[i-1];
			assign up_pri  = pri_q[i-1];
			assign up_own  = own_q[i-1];
			assign up_rep  = rep_q[i-1];
		end

		// neighbour above feeds a pop-lowest shift
		if (i == CAPACITY - 1) begin : g_top
			assign has_dn = 1'b0;
			assign dn_pri = '0;
			assign dn_own = '0;
			assign dn_rep = '0;
		end else begin : g_mid
			assign has_dn = 1'b1;
			assign dn_pri = pri_q[i+1];
			assign dn_own = own_q[i+1];
			assign dn_rep = rep_q[i+1];
		end

		// new entry lands where the run of smaller keys ends
		assign take_new = !lt_q[i] && lt_prev;
		assign take_up  = (i != 0) && !lt_q[i] && !lt_prev && (OCC_W'(i) <= occ_q);

		// compare stage
		always_ff @(posedge clk) begin
			if (ctl.compare) begin
				lt_q[i]    <= valid && (pri_q[i] < prio_q);
				eq_q[i]    <= valid && (pri_q[i] == prio_q);
				sat_q[i]   <= valid && (pri_q[i] == prio_q) && (rep_q[i] == REPEAT_MAX);
				last_q[i]  <= valid && !valid_next;
				multi_q[i] <= valid && !valid_next && (rep_q[i] != REPEAT_ONE);
			end
		end

		// update stage
		always_ff @(posedge clk) begin
			if (ctl.apply) begin
				unique case (cmd_q)
					CMD_INSERT: begin
						if (!drop) begin
							if (dup) begin
								if (eq_q[i]) begin
									rep_q[i] <= rep_q[i] + REPEAT_ONE;
								end
							end else if (take_new) begin
								pri_q[i] <= prio_q;
								own_q[i] <= id_q;
								rep_q[i] <= REPEAT_ONE;
							end else if (take_up) begin
								pri_q[i] <= up_pri;
								own_q[i] <= up_own;
								rep_q[i] <= up_rep;
							end
						end
					end
					CMD_POP_LO: begin
						if (!empty) begin
							if (rep_q[0] != REPEAT_ONE) begin
								if (i == 0) begin
									rep_q[i] <= rep_q[i] - REPEAT_ONE;
								end
							end else if (has_dn) begin
								pri_q[i] <= dn_pri;
								own_q[i] <= dn_own;
								rep_q[i] <= dn_rep;
							end
						end
					end
					CMD_POP_HI: begin
						if (!empty && multi_q[i]) begin
							rep_q[i] <= rep_q[i] - REPEAT_ONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.apply) begin
			unique case (cmd_q)
				CMD_INSERT: begin
					if (!drop && !dup) begin
						occ_q <= occ_q + 1'b1;
					end
				end
				CMD_POP_LO: begin
					if (!empty && (rep_q[0] == REPEAT_ONE)) begin
						occ_q <= occ_q - 1'b1;
					end
				end
				CMD_POP_HI: begin
					if (!empty && hi_remove) begin
						occ_q <= occ_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.apply && res_needed) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply && res_needed) begin
			if (!is_pop) begin
				out_id_q     <= '0;
				out_status_q <= ST_FULL;
			end else if (empty) begin
				out_id_q     <= '0;
				out_status_q <= ST_EMPTY;
			end else begin
				out_id_q     <= (cmd_q == CMD_POP_LO) ? own_q[0] : hi_id;
				out_status_q <= ST_OK;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_id     = out_id_q;
	assign out_status = out_status_q;

	`DEPQ_ASSERT_ALWAYS(a_occ_bound, occ_q <= OCC_FULL, "fill count beyond capacity")
	`DEPQ_ASSERT(a_occ_hold, !ctl.apply |=> $stable(occ_q), "fill count moved outside update")
	`DEPQ_ASSERT(a_empty_pop, (ctl.apply && is_pop && empty) |=> (out_valid_q && out_status_q == ST_EMPTY), "empty pop not reported")

endmodule

// File: src/double_ended_priority_queue_unit.sv
// Double-ended priority queue. Each transfer on the slave side is a command,
// carried in s_axis_tuser (0 insert, 1 pop highest, 2 pop lowest; 3 is ignored).
// Entries sit in a row of cells kept in ascending priority order; inserting a
// priority already present bumps that entry's repeat count and keeps its first
// client id. Pops return the id of the top or bottom entry on the master side
// with a status (0 ok, 1 empty, 2 insert dropped because full or the count is
// saturated); a successful insert gives no result. Every command passes through
// capture, the compare of all cells against the key and the shift or update of
// the cells, in that order, and a new command is taken only once the last one
// has left the update. A result waits in the output register; the next command
// is captured and compared meanwhile, and its update holds only if it too has a
// result and the register is still full. Nothing needs clearing after reset.
module double_ended_priority_queue_unit #(
	parameter int CAPACITY      = depq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = depq_pkg::DEF_PRIORITY_BITS,
	parameter int ID_BITS       = depq_pkg::DEF_ID_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// client_id, priority_req, zero padding
	input  logic [((ID_BITS + PRIORITY_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// cmd
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// served_id, zero padding
	output logic [((ID_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// status
	output logic [1:0] m_axis_tuser
);
	import depq_pkg::*;

	localparam int OUT_W = ((ID_BITS + 7) / 8) * 8;

	ctl_t               ctl;
	sts_t               sts;
	logic [ID_BITS-1:0] served_id;

	depq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.ctl           (ctl)
	);

	depq_store #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS),
		.ID_BITS       (ID_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.in_cmd     (s_axis_tuser),
		.in_id      (s_axis_tdata[ID_BITS-1:0]),
		.in_prio    (s_axis_tdata[ID_BITS +: PRIORITY_BITS]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_id     (served_id),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = OUT_W'(served_id);

endmodule
